FILE: hw/rtl/rsa_pkg.sv
// Shared types, codes and constants for the ring slot allocator.
// No dependencies; rsa_ctrl, rsa_dp, rsa_checker and the top level import it.
`default_nettype none
package rsa_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int OWNER_W        = 22;
  localparam int BYTE_W         = 16;
  localparam int OFFS_W         = 17;
  localparam int GEO_W          = BYTE_W + 2 * OFFS_W;
  localparam logic [BYTE_W-1:0] LIMIT_RESET = 16'd4064;

  typedef enum logic [2:0] {
    F_ALLOC        = 3'd0,
    F_READ         = 3'd1,
    F_RELEASE      = 3'd2,
    F_PURGE        = 3'd3,
    F_GROW_FRONT   = 3'd4,
    F_GROW_BACK    = 3'd5,
    F_SHRINK_FRONT = 3'd6,
    F_SHRINK_BACK  = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_TOO_BIG   = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_NO_ROOM   = 3'd5,
    ST_OVERFLOW  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_PWALK,
    S_PCHK,
    S_TRD,
    S_TCHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    load;
    logic    alloc;
    logic    set_err;
    status_t err;
    logic    rel_write;
    logic    walk_init;
    logic    walk_read;
    logic    walk_clear;
    logic    walk_next;
    logic    tail_read;
    logic    tail_next;
    logic    idx_read;
    logic    exec;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  idx_bad;
    logic  empty;
    logic  idx_tail;
    logic  walk_done;
    logic  tail_done;
    logic  owner_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ring_slot_allocator_with_owners.sv
// Top level of the ring slot allocator: controller plus datapath.
// Depends on rsa_pkg, rsa_ctrl, rsa_dp (and rsa_ram through rsa_dp).
//
// Usage:
//   Input channel in_valid/in_stall carries one request (func, slot_index,
//   owner, headspace, length, tailspace, amount). Result channel
//   out_valid/out_stall carries status, slot_out, offset, data_length, one
//   result per request. cfg_valid/cfg_ready writes slot_byte_limit; cfg_ready
//   is always high; the user must make writes while the block is idle (unenforced).
//   One request is worked at a time; in_stall is low only in the idle state.
//   States after acceptance: every request passes decode and ends in response.
//     Allocate, bad index and empty ring go from decode to response; read and
//     resize add an execute state after the RAM read; release off the tail goes
//     to response; release of the tail slot then reads and checks each tail
//     slot (TRD, TCHK) until the tail reaches the head or a live slot; purge
//     first walks each slot from tail to head (PWALK, PCHK), then steps the tail.
//   The owner and descriptor RAMs (one read port each) set the walk rate.
//   A new request is accepted in the cycle after the result is loaded.
//   The output register holds a result while out_stall is high; the next
//   request is still accepted and waits in the response state.
//   Reset (rst_n low, synchronous) empties the ring (head = tail = 0), sets the
//   limit to 4064 and drops any pending result; RAM contents are not cleared.
`default_nettype none
module ring_slot_allocator_with_owners import rsa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_func,
  input  wire logic [8:0]          in_slot_index,
  input  wire logic [OWNER_W-1:0]  in_owner,
  input  wire logic [BYTE_W-1:0]   in_headspace,
  input  wire logic [BYTE_W-1:0]   in_length,
  input  wire logic [BYTE_W-1:0]   in_tailspace,
  input  wire logic [BYTE_W-1:0]   in_amount,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               out_status,
  output logic [7:0]               out_slot_out,
  output logic [OFFS_W-1:0]        out_offset,
  output logic [OFFS_W-1:0]        out_data_length,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [BYTE_W-1:0]   cfg_data
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsa_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .in_func         (in_func),
    .in_slot_index   (in_slot_index),
    .in_owner        (in_owner),
    .in_headspace    (in_headspace),
    .in_length       (in_length),
    .in_tailspace    (in_tailspace),
    .in_amount       (in_amount),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_status),
    .out_slot_out    (out_slot_out),
    .out_offset      (out_offset),
    .out_data_length (out_data_length)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/rsa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module rsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rsa_dp.sv
// Datapath: request registers, ring pointers, descriptor RAMs and result registers.
// Depends on rsa_pkg and rsa_ram; driven by rsa_ctrl commands.
`default_nettype none
module rsa_dp import rsa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [BYTE_W-1:0]   cfg_data,
  input  wire logic [2:0]          in_func,
  input  wire logic [8:0]          in_slot_index,
  input  wire logic [OWNER_W-1:0]  in_owner,
  input  wire logic [BYTE_W-1:0]   in_headspace,
  input  wire logic [BYTE_W-1:0]   in_length,
  input  wire logic [BYTE_W-1:0]   in_tailspace,
  input  wire logic [BYTE_W-1:0]   in_amount,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  output logic [2:0]               out_status,
  output logic [7:0]               out_slot_out,
  output logic [OFFS_W-1:0]        out_offset,
  output logic [OFFS_W-1:0]        out_data_length
);
  localparam int PW = $clog2(SLOT_COUNT);
  localparam logic [PW-1:0] LAST = PW'(SLOT_COUNT - 1);

  func_t              func_r;
  logic [8:0]         idx_r;
  logic [OWNER_W-1:0] owner_r;
  logic [BYTE_W-1:0]  hs_r, len_r, ts_r, amt_r;
  logic [PW-1:0]      head_r, tail_r, walk_r;
  logic [BYTE_W-1:0]  limit_r;
  status_t            res_status_r;
  logic [7:0]         res_slot_r;
  logic [OFFS_W-1:0]  res_offs_r, res_dlen_r;

  logic [PW-1:0]      head_inc, tail_inc, walk_inc, idx_addr, rd_addr;
  logic [17:0]        size_sum;
  logic               too_big, full, alloc_ok, rd_en;
  logic [OWNER_W-1:0] rd_owner;
  logic [GEO_W-1:0]   rd_geo, geo_wdata;
  logic               own_we, geo_we;
  logic [PW-1:0]      own_waddr, geo_waddr;
  logic [OWNER_W-1:0] own_wdata;
  logic [BYTE_W-1:0]  g_size;
  logic [OFFS_W-1:0]  g_start, g_end, span, new_start, new_end;
  status_t            ex_status;
  logic [OFFS_W-1:0]  ex_offs, ex_dlen;

  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign walk_inc = (walk_r == LAST) ? '0 : walk_r + 1'b1;
  assign idx_addr = PW'(idx_r);
  assign size_sum = 18'(hs_r) + 18'(len_r) + 18'(ts_r);
  assign too_big  = size_sum > {2'b00, limit_r};
  assign full     = head_inc == tail_r;
  assign alloc_ok = cmd.alloc && !too_big && !full;

  assign sts.func       = func_r;
  assign sts.idx_bad    = {8'd0, idx_r} >= 17'(SLOT_COUNT);
  assign sts.empty      = head_r == tail_r;
  assign sts.idx_tail   = idx_addr == tail_r;
  assign sts.walk_done  = walk_r == head_r;
  assign sts.tail_done  = tail_r == head_r;
  assign sts.owner_free = rd_owner == '0;

  assign rd_en   = cmd.walk_read || cmd.tail_read || cmd.idx_read;
  assign rd_addr = cmd.walk_read ? walk_r : (cmd.tail_read ? tail_r : idx_addr);

  always_comb begin
    own_we    = 1'b0;
    own_waddr = head_r;
    own_wdata = owner_r;
    if (alloc_ok) begin
      own_we = 1'b1;
    end else if (cmd.rel_write) begin
      own_we    = 1'b1;
      own_waddr = idx_addr;
      own_wdata = '0;
    end else if (cmd.walk_clear && rd_owner == owner_r) begin
      own_we    = 1'b1;
      own_waddr = walk_r;
      own_wdata = '0;
    end
  end

  assign g_size  = rd_geo[GEO_W-1 -: BYTE_W];
  assign g_start = rd_geo[2*OFFS_W-1 -: OFFS_W];
  assign g_end   = rd_geo[OFFS_W-1:0];
  assign span    = g_end - g_start;

  always_comb begin
    ex_status = ST_OK;
    ex_offs   = '0;
    ex_dlen   = '0;
    new_start = g_start;
    new_end   = g_end;
    case (func_r)
      F_READ: begin
        ex_offs = g_start;
        ex_dlen = span;
      end
      F_GROW_FRONT: begin
        if ({1'b0, amt_r} > g_start) begin
          ex_status = ST_NO_ROOM;
        end else begin
          new_start = g_start - OFFS_W'(amt_r);
          ex_offs   = new_start;
        end
      end
      F_GROW_BACK: begin
        if (18'(g_end) + 18'(amt_r) >= 18'(g_size)) begin
          ex_status = ST_NO_ROOM;
        end else begin
          new_end = g_end + OFFS_W'(amt_r);
          ex_offs = new_end;
        end
      end
      F_SHRINK_FRONT, F_SHRINK_BACK: begin
        if ({1'b0, amt_r} > span) begin
          ex_status = ST_OVERFLOW;
        end else if (func_r == F_SHRINK_FRONT) begin
          new_start = g_start + OFFS_W'(amt_r);
          ex_offs   = new_start;
        end else begin
          new_end = g_end - OFFS_W'(amt_r);
          ex_offs = new_end;
        end
      end
      default: begin
        ex_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    geo_we    = 1'b0;
    geo_waddr = idx_addr;
    geo_wdata = {g_size, new_start, new_end};
    if (alloc_ok) begin
      geo_we    = 1'b1;
      geo_waddr = head_r;
      geo_wdata = {size_sum[BYTE_W-1:0], {1'b0, hs_r}, OFFS_W'(17'(hs_r) + 17'(len_r))};
    end else if (cmd.exec && ex_status == ST_OK && func_r != F_READ) begin
      geo_we = 1'b1;
    end
  end

  rsa_ram #(.WIDTH(OWNER_W), .DEPTH(SLOT_COUNT)) u_owner_ram (
    .clk     (clk),
    .wr_en   (own_we),
    .wr_addr (own_waddr),
    .wr_data (own_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_owner)
  );

  rsa_ram #(.WIDTH(GEO_W), .DEPTH(SLOT_COUNT)) u_geo_ram (
    .clk     (clk),
    .wr_en   (geo_we),
    .wr_addr (geo_waddr),
    .wr_data (geo_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_geo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      walk_r  <= '0;
      limit_r <= LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (alloc_ok) begin
        head_r <= head_inc;
      end
      if (cmd.walk_init) begin
        walk_r <= tail_r;
      end else if (cmd.walk_next) begin
        walk_r <= walk_inc;
      end
      if (cmd.tail_next) begin
        tail_r <= tail_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r       <= func_t'(in_func);
      idx_r        <= in_slot_index;
      owner_r      <= in_owner;
      hs_r         <= in_headspace;
      len_r        <= in_length;
      ts_r         <= in_tailspace;
      amt_r        <= in_amount;
      res_status_r <= ST_OK;
      res_slot_r   <= '0;
      res_offs_r   <= '0;
      res_dlen_r   <= '0;
    end else if (cmd.set_err) begin
      res_status_r <= cmd.err;
    end else if (cmd.alloc) begin
      if (too_big) begin
        res_status_r <= ST_TOO_BIG;
      end else if (full) begin
        res_status_r <= ST_FULL;
      end else begin
        res_slot_r <= 8'(head_r);
      end
    end else if (cmd.exec) begin
      res_status_r <= ex_status;
      res_offs_r   <= ex_offs;
      res_dlen_r   <= ex_dlen;
    end
    if (cmd.out_load) begin
      out_status      <= res_status_r;
      out_slot_out    <= res_slot_r;
      out_offset      <= res_offs_r;
      out_data_length <= res_dlen_r;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rsa_ctrl.sv
// Controller state machine: sequences each request and owns the handshakes.
// Depends on rsa_pkg; drives rsa_dp through cmd_t, reads sts_t.
`default_nettype none
module rsa_ctrl import rsa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt, out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.func == F_ALLOC) begin
          state_nxt = S_RESP;
        end else if (sts.func == F_PURGE) begin
          state_nxt = S_PWALK;
        end else if (sts.idx_bad) begin
          state_nxt = S_RESP;
        end else if ((sts.func == F_READ || sts.func == F_RELEASE) && sts.empty) begin
          state_nxt = S_RESP;
        end else if (sts.func == F_RELEASE) begin
          state_nxt = sts.idx_tail ? S_TRD : S_RESP;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC:  state_nxt = S_RESP;
      S_PWALK: state_nxt = sts.walk_done ? S_TRD : S_PCHK;
      S_PCHK:  state_nxt = S_PWALK;
      S_TRD:   state_nxt = sts.tail_done ? S_RESP : S_TCHK;
      S_TCHK:  state_nxt = sts.owner_free ? S_TRD : S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.err = ST_OK;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DECODE: begin
        if (sts.func == F_ALLOC) begin
          cmd.alloc = 1'b1;
        end else if (sts.func == F_PURGE) begin
          cmd.walk_init = 1'b1;
        end else if (sts.idx_bad) begin
          cmd.set_err = 1'b1;
          cmd.err     = ST_BAD_INDEX;
        end else if ((sts.func == F_READ || sts.func == F_RELEASE) && sts.empty) begin
          cmd.set_err = 1'b1;
          cmd.err     = ST_EMPTY;
        end else if (sts.func == F_RELEASE) begin
          cmd.rel_write = 1'b1;
        end else begin
          cmd.idx_read = 1'b1;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_PWALK: begin
        cmd.walk_read = !sts.walk_done;
      end
      S_PCHK: begin
        cmd.walk_clear = 1'b1;
        cmd.walk_next  = 1'b1;
      end
      S_TRD: begin
        cmd.tail_read = !sts.tail_done;
      end
      S_TCHK: begin
        cmd.tail_next = sts.owner_free;
      end
      S_RESP: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rsa_checker.sv
// Port-level checker for the ring slot allocator, with its bind.
// Depends on rsa_pkg; attaches to ring_slot_allocator_with_owners.
`default_nettype none
module rsa_checker import rsa_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [2:0]        out_status,
  input wire logic [7:0]        out_slot_out,
  input wire logic [OFFS_W-1:0] out_offset,
  input wire logic [OFFS_W-1:0] out_data_length
);
  a_reset_drops: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_offset))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_slot_out == '0 && out_offset == '0 && out_data_length == '0)
    else $error("failed request carries nonzero fields");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 3'd7)
    else $error("undefined status code");
endmodule

bind ring_slot_allocator_with_owners rsa_checker u_rsa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_slot_out    (out_slot_out),
  .out_offset      (out_offset),
  .out_data_length (out_data_length)
);
`default_nettype wire

FILE: test/ring_slot_allocator_with_owners_test.sv
// Testbench for ring_slot_allocator_with_owners: directed table, then random phases.
// Checks results against typed rows or a slot ring predictor; needs rsa_pkg and the RTL.
`default_nettype none
module ring_slot_allocator_with_owners_test;
  import rsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 256;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 250;

  typedef struct {
    func_t           func;
    logic [8:0]      slot_index;
    logic [21:0]     owner;
    logic [15:0]     headspace;
    logic [15:0]     length;
    logic [15:0]     tailspace;
    logic [15:0]     amount;
  } request_t;

  typedef struct {
    status_t     status;
    logic [7:0]  slot_out;
    logic [16:0] offset;
    logic [16:0] data_length;
  } result_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  res;
  } table_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_func = '0;
  logic [8:0] in_slot_index = '0;
  logic [21:0] in_owner = '0;
  logic [15:0] in_headspace = '0, in_length = '0, in_tailspace = '0, in_amount = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] out_status;
  logic [7:0] out_slot_out;
  logic [16:0] out_offset, out_data_length;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  ring_slot_allocator_with_owners DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_slot_index(in_slot_index), .in_owner(in_owner), .in_headspace(in_headspace),
    .in_length(in_length), .in_tailspace(in_tailspace), .in_amount(in_amount),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_slot_out(out_slot_out), .out_offset(out_offset),
    .out_data_length(out_data_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  int unsigned slot_owner_m[RING];
  int unsigned slot_size_m[RING];
  int unsigned start_m[RING];
  int unsigned end_m[RING];
  bit          allocated[RING];
  int          head_m = 0;
  int          tail_m = 0;
  int unsigned byte_limit = 4064;

  result_t pending_results[$];
  int      fails = 0;
  int      idle_mode = 0;
  bit      hold_off_req = 0;
  int      quiet_cycles = 0;

  function automatic int ring_next(int p);
    return (p + 1) % RING;
  endfunction

  function automatic int ring_used();
    return (head_m + RING - tail_m) % RING;
  endfunction

  function automatic void reclaim_tail();
    while (tail_m != head_m && slot_owner_m[tail_m] == 0) tail_m = ring_next(tail_m);
  endfunction

  function automatic result_t ring_predict(request_t r);
    result_t res;
    int unsigned sz, span, idx;
    int p;
    res = '{ST_OK, 8'd0, 17'd0, 17'd0};
    idx = r.slot_index;
    if (r.func == F_ALLOC) begin
      sz = r.headspace + r.length + r.tailspace;
      if (sz > byte_limit) begin
        res.status = ST_TOO_BIG;
      end else if (ring_used() + 1 >= RING) begin
        res.status = ST_FULL;
      end else begin
        slot_owner_m[head_m] = r.owner;
        slot_size_m[head_m] = sz;
        start_m[head_m] = r.headspace;
        end_m[head_m] = r.headspace + r.length;
        allocated[head_m] = 1;
        res.slot_out = 8'(head_m);
        head_m = ring_next(head_m);
      end
    end else if (r.func == F_PURGE) begin
      p = tail_m;
      while (p != head_m) begin
        if (slot_owner_m[p] == r.owner) slot_owner_m[p] = 0;
        p = ring_next(p);
      end
      reclaim_tail();
    end else if (idx >= RING) begin
      res.status = ST_BAD_INDEX;
    end else if (r.func == F_READ || r.func == F_RELEASE) begin
      if (head_m == tail_m) begin
        res.status = ST_EMPTY;
      end else if (r.func == F_READ) begin
        res.offset = 17'(start_m[idx]);
        res.data_length = 17'(end_m[idx] - start_m[idx]);
      end else begin
        slot_owner_m[idx] = 0;
        if (idx == tail_m) reclaim_tail();
      end
    end else if (r.func == F_GROW_FRONT) begin
      if (r.amount > start_m[idx]) begin
        res.status = ST_NO_ROOM;
      end else begin
        start_m[idx] -= r.amount;
        res.offset = 17'(start_m[idx]);
      end
    end else if (r.func == F_GROW_BACK) begin
      if (end_m[idx] + r.amount >= slot_size_m[idx]) begin
        res.status = ST_NO_ROOM;
      end else begin
        end_m[idx] += r.amount;
        res.offset = 17'(end_m[idx]);
      end
    end else begin
      span = (end_m[idx] - start_m[idx]) & 17'h1FFFF;
      if (r.amount > span) begin
        res.status = ST_OVERFLOW;
      end else if (r.func == F_SHRINK_FRONT) begin
        start_m[idx] += r.amount;
        res.offset = 17'(start_m[idx]);
      end else begin
        end_m[idx] -= r.amount;
        res.offset = 17'(end_m[idx]);
      end
    end
    return res;
  endfunction

  function automatic bit idle_now(bit sender);
    case (idle_mode)
      1: return sender && ($urandom_range(0, 99) < 74);
      2: return !sender && ($urandom_range(0, 99) < 74);
      3: return $urandom_range(0, 99) < 26;
      default: return 0;
    endcase
  endfunction

  task automatic send_request(request_t r, bit typed, result_t typed_res);
    result_t res;
    while (idle_now(1)) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_func = r.func;
    in_slot_index = r.slot_index;
    in_owner = r.owner;
    in_headspace = r.headspace;
    in_length = r.length;
    in_tailspace = r.tailspace;
    in_amount = r.amount;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = ring_predict(r);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain_results();
    in_valid = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    byte_limit = value;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [8:0] pick_slot(bit need_written);
    int k;
    int unsigned r;
    if (ring_used() > 0 && $urandom_range(0, 99) < 75)
      return 9'((tail_m + $urandom_range(0, ring_used() - 1)) % RING);
    for (k = 0; k < 64; k++) begin
      r = $urandom_range(0, RING - 1);
      if (!need_written || allocated[r]) return 9'(r);
    end
    return 9'($urandom_range(RING, 511));
  endfunction

  function automatic request_t random_request(int style);
    request_t r;
    int w;
    w = $urandom_range(0, 99);
    case (style)
      1: r.func = (w < 85) ? F_ALLOC : (w < 92) ? F_READ : F_GROW_BACK;
      2: r.func = (w < 20) ? F_ALLOC : (w < 70) ? F_RELEASE : (w < 85) ? F_PURGE : F_READ;
      default: begin
        if (w < 35) r.func = F_ALLOC;
        else if (w < 45) r.func = F_READ;
        else if (w < 63) r.func = F_RELEASE;
        else if (w < 68) r.func = F_PURGE;
        else r.func = func_t'($urandom_range(4, 7));
      end
    endcase
    r.owner = 22'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom);
    r.headspace = 16'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 200) : $urandom);
    r.length = 16'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 400) : $urandom);
    r.tailspace = 16'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 200) : $urandom);
    r.amount = 16'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 150) : $urandom);
    if (r.func == F_RELEASE) begin
      w = $urandom_range(0, 9);
      r.slot_index = (w < 3) ? 9'(tail_m) : (w < 9) ? pick_slot(0)
                                                    : 9'($urandom_range(0, 511));
    end else if ($urandom_range(0, 19) == 0) begin
      r.slot_index = 9'($urandom_range(RING, 511));
    end else begin
      r.slot_index = pick_slot(1);
    end
    return r;
  endfunction

  task automatic run_phase(int mode, int count, int style);
    int k;
    idle_mode = mode;
    for (k = 0; k < count; k++) send_request(random_request(style), 0, '{ST_OK, 0, 0, 0});
    drain_results();
  endtask

  table_row_t directed[] = '{
    '{'{F_READ, 9'd0, 22'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1, '{ST_EMPTY, 0, 0, 0}},
    '{'{F_RELEASE, 9'd0, 22'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1, '{ST_EMPTY, 0, 0, 0}},
    '{'{F_READ, 9'd511, 22'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1, '{ST_BAD_INDEX, 0, 0, 0}},
    '{'{F_ALLOC, 9'd0, 22'h3FFFFF, 16'd4064, 16'd0, 16'd0, 16'd0}, 1, '{ST_OK, 0, 0, 0}},
    '{'{F_ALLOC, 9'd0, 22'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0}, 1,
      '{ST_TOO_BIG, 0, 0, 0}},
    '{'{F_ALLOC, 9'd0, 22'd5, 16'd10, 16'd100, 16'd20, 16'd0}, 1, '{ST_OK, 1, 0, 0}},
    '{'{F_READ, 9'd1, 22'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1, '{ST_OK, 0, 10, 100}},
    '{'{F_GROW_FRONT, 9'd1, 22'd0, 16'd0, 16'd0, 16'd0, 16'd11}, 1,
      '{ST_NO_ROOM, 0, 0, 0}},
    '{'{F_GROW_FRONT, 9'd1, 22'd0, 16'd0, 16'd0, 16'd0, 16'd10}, 1, '{ST_OK, 0, 0, 0}},
    '{'{F_GROW_BACK, 9'd1, 22'd0, 16'd0, 16'd0, 16'd0, 16'd20}, 1,
      '{ST_NO_ROOM, 0, 0, 0}},
    '{'{F_GROW_BACK, 9'd1, 22'd0, 16'd0, 16'd0, 16'd0, 16'd19}, 1, '{ST_OK, 0, 129, 0}},
    '{'{F_SHRINK_FRONT, 9'd1, 22'd0, 16'd0, 16'd0, 16'd0, 16'd130}, 1,
      '{ST_OVERFLOW, 0, 0, 0}},
    '{'{F_SHRINK_FRONT, 9'd1, 22'd0, 16'd0, 16'd0, 16'd0, 16'd129}, 1,
      '{ST_OK, 0, 129, 0}},
    '{'{F_SHRINK_BACK, 9'd1, 22'd0, 16'd0, 16'd0, 16'd0, 16'd1}, 1,
      '{ST_OVERFLOW, 0, 0, 0}},
    '{'{F_SHRINK_BACK, 9'd1, 22'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1, '{ST_OK, 0, 129, 0}},
    '{'{F_ALLOC, 9'd0, 22'd5, 16'd0, 16'd0, 16'd0, 16'd0}, 1, '{ST_OK, 2, 0, 0}},
    '{'{F_ALLOC, 9'd0, 22'd0, 16'd7, 16'd8, 16'd9, 16'd0}, 1, '{ST_OK, 3, 0, 0}},
    '{'{F_RELEASE, 9'd0, 22'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{F_PURGE, 9'd0, 22'd5, 16'd0, 16'd0, 16'd0, 16'd0}, 1, '{ST_OK, 0, 0, 0}},
    '{'{F_READ, 9'd1, 22'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1, '{ST_EMPTY, 0, 0, 0}},
    '{'{F_PURGE, 9'd0, 22'd7, 16'd0, 16'd0, 16'd0, 16'd0}, 1, '{ST_OK, 0, 0, 0}},
    '{'{F_ALLOC, 9'd0, 22'd1, 16'd3, 16'd4, 16'd5, 16'd0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{F_RELEASE, 9'd300, 22'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1,
      '{ST_BAD_INDEX, 0, 0, 0}},
    '{'{F_GROW_FRONT, 9'd511, 22'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF}, 1,
      '{ST_BAD_INDEX, 0, 0, 0}}
  };

  always begin
    @(negedge clk);
    if (hold_off_req) begin
      hold_off_req = 0;
      out_stall = 1;
      repeat (HOLD_OFF_CYCLES) @(negedge clk);
    end
    out_stall = idle_now(0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d", out_status);
        fails++;
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status);
          fails++;
        end
        if (out_slot_out !== e.slot_out) begin
          $error("slot_out expected %0d actual %0d", e.slot_out, out_slot_out);
          fails++;
        end
        if (out_offset !== e.offset) begin
          $error("offset expected %0d actual %0d", e.offset, out_offset);
          fails++;
        end
        if (out_data_length !== e.data_length) begin
          $error("data_length expected %0d actual %0d", e.data_length, out_data_length);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    foreach (directed[k]) send_request(directed[k].req, directed[k].typed, directed[k].res);
    drain_results();
    run_phase(0, 200, 0);
    write_limit(16'd0);
    run_phase(1, 100, 0);
    write_limit(16'hFFFF);
    hold_off_req = 1;
    run_phase(2, 350, 1);
    run_phase(3, 300, 0);
    write_limit(16'($urandom_range(100, 3000)));
    run_phase(0, 300, 2);
    repeat (20) @(negedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
